FILE: design/psv_pkg.sv
package psv_pkg;

    localparam int NUM_VOICES_DEF  = 8;
    localparam int SAMPLE_RATE_DEF = 48000;
    localparam int PHASE_BITS_DEF  = 24;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 8;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int LEVEL_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CIDX_W   = 2;
    localparam int SAMPLE_W = 24;
    localparam int SAW_FRAC = 22;
    localparam int SAW_W    = SAW_FRAC + 1;

    localparam logic [ACTION_W-1:0] ACT_MIDI    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REL_ALL = 2'd2;

    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

    localparam logic [CIDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_RELEASE = 2'd1;
    localparam logic [CIDX_W-1:0] REG_GAIN    = 2'd2;

    localparam logic [CFG_W-1:0] ATTACK_RST  = 16'd27;
    localparam logic [CFG_W-1:0] RELEASE_RST = 16'd7;
    localparam logic [CFG_W-1:0] GAIN_RST    = 16'd32768;

    localparam logic [LEVEL_W-1:0] VEL_SCALE = 16'd516;

    localparam int SAMPLE_MAX_I = 8388607;
    localparam int SAMPLE_MIN_I = -8388608;

    typedef enum logic [2:0] {
        VOP_IDLE,
        VOP_NOTE_ON,
        VOP_NOTE_OFF,
        VOP_REL_ALL,
        VOP_TICK
    } vop_t;

    typedef struct packed {
        vop_t              op;
        logic              last;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } voice_cmd_t;

    typedef struct packed {
        logic claim;
    } voice_stat_t;

    typedef struct packed {
        logic [CFG_W-1:0] attack_step;
        logic [CFG_W-1:0] release_step;
        logic [CFG_W-1:0] output_gain;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic signed [SAW_W-1:0] saw;
        logic [LEVEL_W-1:0]      level;
    } mix_in_t;

    // equal-tempered semitone ratios, Q1.30
    function automatic logic [31:0] semitone_q30(input int unsigned k);
        logic [31:0] r;
        case (k)
            0:       r = 32'd1073741824;
            1:       r = 32'd1137589835;
            2:       r = 32'd1205234447;
            3:       r = 32'd1276901417;
            4:       r = 32'd1352829926;
            5:       r = 32'd1433273380;
            6:       r = 32'd1518500250;
            7:       r = 32'd1608794974;
            8:       r = 32'd1704458901;
            9:       r = 32'd1805811301;
            10:      r = 32'd1913190429;
            default: r = 32'd2026954652;
        endcase
        return r;
    endfunction

endpackage

FILE: design/psv_note_rom.sv
module psv_note_rom #(
    parameter int SAMPLE_RATE = psv_pkg::SAMPLE_RATE_DEF,
    parameter int PHASE_BITS  = psv_pkg::PHASE_BITS_DEF
) (
    input  logic [psv_pkg::NOTE_W-1:0] note,
    output logic [PHASE_BITS-1:0]      inc
);
    import psv_pkg::*;

    localparam int NUM_NOTES = 2 ** NOTE_W;

    logic [PHASE_BITS-1:0] rom [NUM_NOTES];

    for (genvar n = 0; n < NUM_NOTES; n++)
    begin : g_note
        localparam int          D    = n + 3;
        localparam int          OCT  = D / 12;
        localparam logic [63:0] NUMV = 64'd440 * 64'(semitone_q30(D % 12));
        localparam int          E    = OCT - 36 + PHASE_BITS;
        localparam int          EP   = (E >= 0) ? E : 0;
        localparam int          EN   = (E < 0) ? -E : 0;
        localparam logic [63:0] DEN  = 64'(SAMPLE_RATE) << EN;
        localparam logic [63:0] INC  = (E >= 0)
            ? (((NUMV << EP) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE))
            : ((NUMV + DEN / 2) / DEN);
        assign rom[n] = INC[PHASE_BITS-1:0];
    end

    assign inc = rom[note];

endmodule

FILE: design/psv_voice_bank.sv
module psv_voice_bank #(
    parameter int NUM_VOICES  = psv_pkg::NUM_VOICES_DEF,
    parameter int SAMPLE_RATE = psv_pkg::SAMPLE_RATE_DEF,
    parameter int PHASE_BITS  = psv_pkg::PHASE_BITS_DEF,
    localparam int VIDX_W     = $clog2(NUM_VOICES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psv_pkg::voice_cmd_t  cmd,
    input  logic [VIDX_W-1:0]    idx,
    input  psv_pkg::cfg_t        cfg,
    output psv_pkg::voice_stat_t stat,
    output psv_pkg::mix_in_t     mix_in
);
    import psv_pkg::*;

    logic [NUM_VOICES-1:0] active_reg;
    logic [NUM_VOICES-1:0] released_reg;
    logic [LEVEL_W-1:0]    level_reg  [NUM_VOICES];
    logic [NOTE_W-1:0]     note_reg   [NUM_VOICES];
    logic [LEVEL_W-1:0]    target_reg [NUM_VOICES];
    logic [PHASE_BITS-1:0] phase_reg  [NUM_VOICES];
    mix_in_t               mix_in_reg;
    mix_in_t               mix_in_next;

    logic                  cur_active;
    logic                  cur_released;
    logic [LEVEL_W-1:0]    cur_level;
    logic [LEVEL_W-1:0]    cur_target;
    logic [NOTE_W-1:0]     cur_note;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [PHASE_BITS-1:0] cur_inc;
    logic [SAW_FRAC-1:0]   s22;
    logic [LEVEL_W:0]      att_sum;
    logic [LEVEL_W-1:0]    level_next;
    logic                  deact;
    logic                  on_we;
    logic                  rel_we;
    logic                  tick_we;
    logic [VIDX_W-1:0]     slot;

    assign cur_active   = active_reg[idx];
    assign cur_released = released_reg[idx];
    assign cur_level    = level_reg[idx];
    assign cur_target   = target_reg[idx];
    assign cur_note     = note_reg[idx];
    assign cur_phase    = phase_reg[idx];

    psv_note_rom #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .PHASE_BITS  (PHASE_BITS)
    ) u_rom (
        .note (cur_note),
        .inc  (cur_inc)
    );

    if (PHASE_BITS >= SAW_FRAC)
    begin : g_saw_hi
        assign s22 = cur_phase[PHASE_BITS-1 -: SAW_FRAC];
    end
    else
    begin : g_saw_lo
        assign s22 = {cur_phase, {(SAW_FRAC - PHASE_BITS){1'b0}}};
    end

    always_comb
    begin
        stat.claim = !cur_active || cmd.last;
        slot       = cur_active ? '0 : idx;
        on_we      = (cmd.op == VOP_NOTE_ON) && stat.claim;
        rel_we     = cur_active && (((cmd.op == VOP_NOTE_OFF) && (cur_note == cmd.note))
                                    || (cmd.op == VOP_REL_ALL));
        tick_we    = (cmd.op == VOP_TICK) && cur_active;

        att_sum    = {1'b0, cur_level} + {1'b0, cfg.attack_step};
        deact      = 1'b0;
        level_next = cur_level;
        if (cur_released)
        begin
            if (cur_level <= cfg.release_step)
            begin
                level_next = '0;
                deact      = 1'b1;
            end
            else
            begin
                level_next = cur_level - cfg.release_step;
            end
        end
        else if (cur_level < cur_target)
        begin
            level_next = (att_sum > {1'b0, cur_target}) ? cur_target : att_sum[LEVEL_W-1:0];
        end

        // saw = 2*s - 2^22
        mix_in_next.valid = tick_we;
        mix_in_next.saw   = {~s22[SAW_FRAC-1], s22[SAW_FRAC-2:0], 1'b0};
        mix_in_next.level = level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            released_reg <= '0;
            mix_in_reg   <= '0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                level_reg[i] <= '0;
            end
        end
        else
        begin
            mix_in_reg <= mix_in_next;
            if (on_we)
            begin
                active_reg[slot]   <= 1'b1;
                released_reg[slot] <= 1'b0;
                level_reg[slot]    <= '0;
            end
            if (rel_we)
            begin
                released_reg[idx] <= 1'b1;
            end
            if (tick_we)
            begin
                level_reg[idx] <= level_next;
                if (deact)
                begin
                    active_reg[idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (on_we)
        begin
            note_reg[slot]   <= cmd.note;
            target_reg[slot] <= LEVEL_W'({{(LEVEL_W - VEL_W){1'b0}}, cmd.velocity} * VEL_SCALE);
            phase_reg[slot]  <= '0;
        end
        if (tick_we)
        begin
            phase_reg[idx] <= cur_phase + cur_inc;
        end
    end

    assign mix_in = mix_in_reg;

endmodule

FILE: design/psv_mix_pipe.sv
module psv_mix_pipe #(
    parameter int NUM_VOICES = psv_pkg::NUM_VOICES_DEF,
    localparam int SUM_W     = psv_pkg::SAMPLE_W + $clog2(NUM_VOICES)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  psv_pkg::mix_in_t        mix_in,
    input  logic [psv_pkg::CFG_W-1:0] gain,
    output logic                    busy,
    output logic signed [SUM_W-1:0] sum
);
    import psv_pkg::*;

    localparam int GL_W   = CFG_W + LEVEL_W;
    localparam int P_W    = SAW_W + GL_W + 1;
    localparam int HI_W   = SAW_W;
    localparam int Q_W    = 2 * HI_W;
    localparam int DIV5_K = 25;
    localparam logic [HI_W-1:0] DIV5_MULT = 23'd6710887;   // ceil(2^25 / 5)

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic [GL_W-1:0]         gl_reg;
    logic signed [SAW_W-1:0] saw1_reg;
    logic signed [P_W-1:0]   p_reg;
    logic [P_W-1:0]          mag;
    logic                    neg3_reg, neg4_reg;
    logic [HI_W-1:0]         hi3_reg;
    logic [Q_W-1:0]          q4_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] contrib_mag;
    logic signed [GL_W:0]    gl_s;

    assign gl_s = {1'b0, gl_reg};
    assign mag  = p_reg[P_W-1] ? (~p_reg + 1'b1) : p_reg;

    always_comb
    begin
        contrib_mag = SUM_W'(q4_reg[Q_W-1:DIV5_K]);
        sum_next    = sum_reg;
        if (clear)
        begin
            sum_next = '0;
        end
        else if (v4_reg)
        begin
            sum_next = neg4_reg ? (sum_reg - contrib_mag) : (sum_reg + contrib_mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            sum_reg <= '0;
        end
        else
        begin
            v1_reg  <= mix_in.valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gl_reg   <= {{LEVEL_W{1'b0}}, gain} * {{CFG_W{1'b0}}, mix_in.level};
        saw1_reg <= mix_in.saw;
        p_reg    <= saw1_reg * gl_s;
        neg3_reg <= p_reg[P_W-1];
        hi3_reg  <= mag[P_W-2 -: HI_W];
        neg4_reg <= neg3_reg;
        q4_reg   <= hi3_reg * DIV5_MULT;
    end

    assign busy = mix_in.valid | v1_reg | v2_reg | v3_reg | v4_reg;
    assign sum  = sum_reg;

endmodule

FILE: design/poly_saw_synth_voice_engine.sv
// Channel  Dir  Handshake              Payload
// s_       in   s_tvalid / s_tready    tuser: action; tdata: status, note, velocity
// m_       out  m_tvalid / m_tready    tdata: sample (Q2.22, saturated)
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every item is accepted in idle. A tick then walks all NUM_VOICES voices, drains the
// multiply pipe and loads the output register. Note-on walks until the first free voice
// (at the last voice it claims voice 0 if all voices are busy); note-off and all-off
// walk all NUM_VOICES voices. Other events are accepted without leaving idle.
// Reset clears all voices and loads register defaults; cfg_ready is always high.
// A finished sample waits in the output register; a following tick stalls before
// loading it until the register is free.
module poly_saw_synth_voice_engine #(
    parameter int NUM_VOICES  = psv_pkg::NUM_VOICES_DEF,
    parameter int SAMPLE_RATE = psv_pkg::SAMPLE_RATE_DEF,
    parameter int PHASE_BITS  = psv_pkg::PHASE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // status_byte[7:0], note_number[14:8],
                                                     // velocity[21:15], zero[23:22]
    input  logic [psv_pkg::ACTION_W-1:0]  s_tuser,   // action[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psv_pkg::SAMPLE_W-1:0]  m_tdata,   // sample[23:0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [psv_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [psv_pkg::CFG_W-1:0]     cfg_data
);
    import psv_pkg::*;

    localparam int VIDX_W = $clog2(NUM_VOICES);
    localparam int SUM_W  = SAMPLE_W + $clog2(NUM_VOICES);
    localparam logic [VIDX_W-1:0]     LAST_IDX = VIDX_W'(NUM_VOICES - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAMPLE_MAX_I);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SAMPLE_MIN_I);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    state_t                  state_reg, state_next;
    vop_t                    op_reg, op_next;
    logic [NOTE_W-1:0]       note_reg, note_next;
    logic [VEL_W-1:0]        vel_reg, vel_next;
    logic [VIDX_W-1:0]       idx_reg, idx_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]     m_tdata_reg, m_tdata_next;
    cfg_t                    cfg_reg;

    logic [STATUS_W-1:0]     in_status;
    logic [NOTE_W-1:0]       in_note;
    logic [VEL_W-1:0]        in_vel;
    voice_cmd_t              cmd;
    voice_stat_t             vstat;
    mix_in_t                 mix_in;
    logic                    mix_clear;
    logic                    mix_busy;
    logic signed [SUM_W-1:0] mix_sum;
    logic [SAMPLE_W-1:0]     sat;

    assign in_status = s_tdata[7:0];
    assign in_note   = s_tdata[14:8];
    assign in_vel    = s_tdata[21:15];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign cmd.op       = (state_reg == ST_WALK) ? op_reg : VOP_IDLE;
    assign cmd.last     = (idx_reg == LAST_IDX);
    assign cmd.note     = note_reg;
    assign cmd.velocity = vel_reg;

    assign mix_clear = s_tvalid && s_tready && (s_tuser == ACT_TICK);

    assign sat = (mix_sum > SAT_HI) ? SAT_HI[SAMPLE_W-1:0]
               : (mix_sum < SAT_LO) ? SAT_LO[SAMPLE_W-1:0]
               : mix_sum[SAMPLE_W-1:0];

    psv_voice_bank #(
        .NUM_VOICES  (NUM_VOICES),
        .SAMPLE_RATE (SAMPLE_RATE),
        .PHASE_BITS  (PHASE_BITS)
    ) u_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .idx    (idx_reg),
        .cfg    (cfg_reg),
        .stat   (vstat),
        .mix_in (mix_in)
    );

    psv_mix_pipe #(
        .NUM_VOICES (NUM_VOICES)
    ) u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (mix_clear),
        .mix_in (mix_in),
        .gain   (cfg_reg.output_gain),
        .busy   (mix_busy),
        .sum    (mix_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step  <= ATTACK_RST;
            cfg_reg.release_step <= RELEASE_RST;
            cfg_reg.output_gain  <= GAIN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ATTACK:  cfg_reg.attack_step  <= cfg_data;
                REG_RELEASE: cfg_reg.release_step <= cfg_data;
                REG_GAIN:    cfg_reg.output_gain  <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        note_next     = note_reg;
        vel_next      = vel_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    note_next = in_note;
                    vel_next  = in_vel;
                    idx_next  = '0;
                    case (s_tuser)
                        ACT_TICK:
                        begin
                            op_next    = VOP_TICK;
                            state_next = ST_WALK;
                        end
                        ACT_REL_ALL:
                        begin
                            op_next    = VOP_REL_ALL;
                            state_next = ST_WALK;
                        end
                        ACT_MIDI:
                        begin
                            case (in_status[7:4])
                                KIND_NOTE_ON:
                                begin
                                    op_next    = (in_vel != '0) ? VOP_NOTE_ON : VOP_NOTE_OFF;
                                    state_next = ST_WALK;
                                end
                                KIND_NOTE_OFF:
                                begin
                                    op_next    = VOP_NOTE_OFF;
                                    state_next = ST_WALK;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (cmd.last || ((op_reg == VOP_NOTE_ON) && vstat.claim))
                begin
                    idx_next   = '0;
                    state_next = (op_reg == VOP_TICK) ? ST_DRAIN : ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!mix_busy && (!m_tvalid_reg || m_tready))
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = sat;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= VOP_IDLE;
            note_reg     <= '0;
            vel_reg      <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            note_reg     <= note_next;
            vel_reg      <= vel_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

endmodule

FILE: design/psv_checker.sv
module psv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [psv_pkg::ACTION_W-1:0]  s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [psv_pkg::SAMPLE_W-1:0]  m_tdata
);
    import psv_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output item changed while stalled");

    a_busy_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_TICK || s_tuser == ACT_REL_ALL)
        |=> !s_tready)
        else $error("input ready right after a voice walk started");

    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a tick in progress");

endmodule

bind poly_saw_synth_voice_engine psv_checker u_psv_checker (.*);
